// File: rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the min-tracking stack
// Request codes, status codes, shift control word and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // shift command applied to every cell of a chain in the same cycle
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

`default_nettype wire

// File: rtl/mts_cell.sv
// ----------------------------------------------------------------------------
// mts_cell: one stack slot
// Holds one word; loads from the slot above on push, from below on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_cell #(
    parameter int DATA_WIDTH = mts_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire mts_pkg::t_shift_ctl   i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_from_above,
    input  wire logic [DATA_WIDTH-1:0] i_from_below,
    output logic      [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push) begin
            n_data = i_from_above;
        end else if (i_ctl.pop) begin
            n_data = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: rtl/mts_chain.sv
// ----------------------------------------------------------------------------
// mts_chain: shift-register stack built from a row of cells
// Cell 0 is the top of stack; pushes shift down, pops shift up.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_chain #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = mts_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire mts_pkg::t_shift_ctl   i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    output logic      [DATA_WIDTH-1:0] o_top,
    output logic      [DATA_WIDTH-1:0] o_second
);

    logic [DATA_WIDTH-1:0] w_data [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_above;
        logic [DATA_WIDTH-1:0] w_below;

        if (g == 0) begin : g_head
            assign w_above = i_data;
        end else begin : g_body
            assign w_above = w_data[g-1];
        end

        // bottom slot pulls in filler; it is beyond the count and never read
        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_below = '0;
        end else begin : g_link
            assign w_below = w_data[g+1];
        end

        mts_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_above(w_above),
            .i_from_below(w_below),
            .o_data      (w_data[g])
        );
    end

    assign o_top    = w_data[0];
    assign o_second = w_data[1];

endmodule

`default_nettype wire

// File: rtl/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top: bounded LIFO stack with running minimum
// Value stack plus a stack of minima, both as shift chains of cells.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | word
//  --------+-------------------------+------------------------------------------
//  request | i_in_valid / o_in_ready | i_req_type, i_push_value
//  result  | o_out_valid/i_out_ready | o_pop_value, o_min_value, o_min_valid,
//          |                         | o_depth_now, o_status
//
//  One request per cycle while the output slot is free or draining. A request
//  is evaluated the cycle it is accepted; its result word shows up in the
//  output register on the next cycle. Both stacks shift all cells at once,
//  so the tops stay at cell 0; the single output register sets the rate.
//  Sync active-low reset empties both stacks (counts cleared; cell data kept).
//  While a result waits unclaimed, a new request is taken only in the cycle
//  the waiting word is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = mts_pkg::DEF_DATA_WIDTH,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_req_type,
    input  wire logic signed [DATA_WIDTH-1:0] i_push_value,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed      [DATA_WIDTH-1:0] o_pop_value,
    output logic signed      [DATA_WIDTH-1:0] o_min_value,
    output logic                              o_min_valid,
    output logic             [CNT_W-1:0]      o_depth_now,
    output logic             [1:0]            o_status
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    // stack counts
    logic [CNT_W-1:0] r_vcount, n_vcount;
    logic [CNT_W-1:0] r_mcount, n_mcount;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_pop_value, n_pop_value;
    logic [DATA_WIDTH-1:0] r_min_value, n_min_value;
    logic                  r_min_valid, n_min_valid;
    logic [CNT_W-1:0]      r_depth_now;
    mts_pkg::t_status      r_status, n_status;

    logic in_acc;
    logic push_ok, pop_ok, min_push, min_pop;
    mts_pkg::t_shift_ctl val_ctl, min_ctl;
    logic [DATA_WIDTH-1:0] val_top, val_second;
    logic [DATA_WIDTH-1:0] min_top, min_second;

    // input taken whenever the output slot is free or draining this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    mts_chain #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_values (
        .i_clk   (i_clk),
        .i_ctl   (val_ctl),
        .i_data  (i_push_value),
        .o_top   (val_top),
        .o_second(val_second)
    );

    mts_chain #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_minima (
        .i_clk   (i_clk),
        .i_ctl   (min_ctl),
        .i_data  (i_push_value),
        .o_top   (min_top),
        .o_second(min_second)
    );

    always_comb begin
        push_ok = in_acc && (i_req_type == mts_pkg::REQ_PUSH) && (r_vcount != FULL_CNT);
        pop_ok  = in_acc && (i_req_type == mts_pkg::REQ_POP) && (r_vcount != '0);

        // equal values go onto the minima stack too, so duplicates pop cleanly
        min_push = push_ok && ((r_mcount == '0) ||
                               ($signed(i_push_value) <= $signed(min_top)));
        min_pop  = pop_ok && (r_mcount != '0) && (min_top == val_top);

        val_ctl.push = push_ok;
        val_ctl.pop  = pop_ok;
        min_ctl.push = min_push;
        min_ctl.pop  = min_pop;

        n_vcount = r_vcount;
        if (push_ok) begin
            n_vcount = r_vcount + CNT_W'(1);
        end else if (pop_ok) begin
            n_vcount = r_vcount - CNT_W'(1);
        end

        n_mcount = r_mcount;
        if (min_push) begin
            n_mcount = r_mcount + CNT_W'(1);
        end else if (min_pop) begin
            n_mcount = r_mcount - CNT_W'(1);
        end

        n_status = mts_pkg::ST_OK;
        if (i_req_type == mts_pkg::REQ_PUSH && !push_ok) begin
            n_status = mts_pkg::ST_FULL;
        end else if (i_req_type == mts_pkg::REQ_POP && !pop_ok) begin
            n_status = mts_pkg::ST_EMPTY;
        end

        n_pop_value = pop_ok ? val_top : '0;

        // minimum after the operation, forwarded from the chain inputs
        n_min_valid = (n_vcount != '0) && (n_mcount != '0);
        if (!n_min_valid) begin
            n_min_value = '0;
        end else if (min_push) begin
            n_min_value = i_push_value;
        end else if (min_pop) begin
            n_min_value = min_second;
        end else begin
            n_min_value = min_top;
        end

        n_out_valid = r_out_valid;
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= '0;
            r_mcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vcount    <= n_vcount;
            r_mcount    <= n_mcount;
            r_out_valid <= n_out_valid;
        end
    end

    // result word, loaded on accept
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pop_value <= n_pop_value;
            r_min_value <= n_min_value;
            r_min_valid <= n_min_valid;
            r_depth_now <= n_vcount;
            r_status    <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_min_value = r_min_value;
    assign o_min_valid = r_min_valid;
    assign o_depth_now = r_depth_now;
    assign o_status    = r_status;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount <= FULL_CNT)
        else $error("value count beyond stack depth");

    a_min_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcount <= r_vcount)
        else $error("minima count exceeds value count");

    a_min_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vcount != '0) |-> (r_mcount != '0))
        else $error("non-empty stack with empty minima stack");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == mts_pkg::REQ_PUSH && r_vcount == FULL_CNT)
        |=> (o_status == mts_pkg::ST_FULL && $stable(r_vcount)))
        else $error("push on full stack not dropped and flagged");

    a_depth_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (o_depth_now == r_vcount))
        else $error("reported depth differs from count");

    // a pop lifts the second entry to the top
    a_pop_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && r_vcount >= CNT_W'(2)) |=> (val_top == $past(val_second)))
        else $error("pop did not shift the value chain up");

endmodule

`default_nettype wire

// File: tb/min_tracking_stack_checker.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_checker: result predictor and comparator
// Watches both channels of the min-tracking stack, keeps its own copy of the
// value and minima stacks, and compares every result word field by field.
// ----------------------------------------------------------------------------
module min_tracking_stack_checker #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = mts_pkg::DEF_DATA_WIDTH,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_push_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [DATA_WIDTH-1:0] i_pop_value,
    input  logic signed [DATA_WIDTH-1:0] i_min_value,
    input  logic                         i_min_valid,
    input  logic        [CNT_W-1:0]      i_depth_now,
    input  logic        [1:0]            i_status,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_full_drops,
    output int                           o_empty_pops
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pop_value;
        logic signed [DATA_WIDTH-1:0] min_value;
        logic                         min_valid;
        logic        [CNT_W-1:0]      depth_now;
        mts_pkg::t_status             status;
    } t_stack_result;

    // shadow copy of both stacks
    logic signed [DATA_WIDTH-1:0] value_mem  [STACK_DEPTH];
    logic signed [DATA_WIDTH-1:0] minima_mem [STACK_DEPTH];
    int                           value_depth;
    int                           minima_depth;

    t_stack_result pending_results[$];
    int            error_count;
    int            results_seen;
    int            full_count;
    int            empty_count;

    function automatic t_stack_result apply_stack_op(logic req,
                                                     logic signed [DATA_WIDTH-1:0] word_in);
        t_stack_result                res;
        logic signed [DATA_WIDTH-1:0] popped;
        popped     = '0;
        res.status = mts_pkg::ST_OK;
        if (req == mts_pkg::REQ_PUSH) begin
            if (value_depth >= STACK_DEPTH) begin
                res.status = mts_pkg::ST_FULL;
            end else begin
                value_mem[value_depth] = word_in;
                value_depth++;
                // ties go onto the minima stack so duplicates unwind correctly
                if ((minima_depth == 0 || word_in <= minima_mem[minima_depth-1]) &&
                    minima_depth < STACK_DEPTH) begin
                    minima_mem[minima_depth] = word_in;
                    minima_depth++;
                end
            end
        end else if (value_depth == 0) begin
            res.status = mts_pkg::ST_EMPTY;
        end else begin
            value_depth--;
            popped = value_mem[value_depth];
            if (minima_depth > 0 && minima_mem[minima_depth-1] == popped)
                minima_depth--;
        end
        res.pop_value = popped;
        res.min_valid = (value_depth > 0 && minima_depth > 0);
        res.min_value = res.min_valid ? minima_mem[minima_depth-1] : '0;
        res.depth_now = CNT_W'(value_depth);
        return res;
    endfunction

    task automatic report_error(string msg);
        error_count++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic signed [63:0] got,
                               logic signed [63:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            value_depth  = 0;
            minima_depth = 0;
            pending_results.delete();
            error_count  = 0;
            results_seen = 0;
            full_count   = 0;
            empty_count  = 0;
        end else begin
            // drain first: a word leaving now belongs to an older request
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_error("result word with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    check_field("pop_value", i_pop_value, want.pop_value);
                    check_field("min_value", i_min_value, want.min_value);
                    check_field("min_valid", i_min_valid, want.min_valid);
                    check_field("depth_now", i_depth_now, want.depth_now);
                    check_field("status", i_status, want.status);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                want = apply_stack_op(i_req_type, i_push_value);
                if (want.status == mts_pkg::ST_FULL)  full_count++;
                if (want.status == mts_pkg::ST_EMPTY) empty_count++;
                pending_results.push_back(want);
            end
        end
        o_fail_count <= error_count;
        o_pending    <= pending_results.size();
        o_checked    <= results_seen;
        o_full_drops <= full_count;
        o_empty_pops <= empty_count;
    end

endmodule

// File: tb/min_tracking_stack_top_tb.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top_tb: stimulus and verdict for the min-tracking stack
// Directed corner words, then biased random push/pop bursts under three
// handshake-pressure phases; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module min_tracking_stack_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = mts_pkg::DEF_STACK_DEPTH;
    localparam int DATA_WIDTH   = mts_pkg::DEF_DATA_WIDTH;
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
    localparam int RESET_CYCLES = 11;
    // spare drain cycles after the last result catch stray result words
    localparam int DRAIN_CYCLES = 8;
    // cycle budget for ~1300 words under 80% gaps or stalls, with a wide margin
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // fill pattern: extremes, zero, repeated minima and repeated non-minima
    localparam logic signed [DATA_WIDTH-1:0] FILL_WORDS [STACK_DEPTH] = '{
        WORD_MAX, 10, 10, -3, 0, -3, WORD_MIN, WORD_MIN,
        -1, 12, WORD_MIN, 5, 3, 0, -5, WORD_MAX
    };

    // ------------------------------------------------------------------
    // DUT-facing signals; the driven ones are known from time zero
    // ------------------------------------------------------------------
    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         req_type     = mts_pkg::REQ_PUSH;
    logic signed [DATA_WIDTH-1:0] push_value   = '0;
    logic                         out_ready    = 1'b0;

    logic                         in_ready;
    logic                         out_valid;
    logic signed [DATA_WIDTH-1:0] pop_value;
    logic signed [DATA_WIDTH-1:0] min_value;
    logic                         min_valid;
    logic        [CNT_W-1:0]      depth_now;
    logic        [1:0]            status;

    int fail_count;
    int pending;
    int checked;
    int full_drops;
    int empty_pops;

    // pressure knobs, percent of cycles spent idle / stalled
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int words_sent    = 0;
    int directed_sent = 0;
    int cycle_count   = 0;

    min_tracking_stack_top #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_push_value (push_value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_pop_value  (pop_value),
        .o_min_value  (min_value),
        .o_min_valid  (min_valid),
        .o_depth_now  (depth_now),
        .o_status     (status)
    );

    min_tracking_stack_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .CNT_W       (CNT_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_push_value (push_value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_pop_value  (pop_value),
        .i_min_value  (min_value),
        .i_min_valid  (min_valid),
        .i_depth_now  (depth_now),
        .i_status     (status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_drops (full_drops),
        .o_empty_pops (empty_pops)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver: ready drawn fresh each cycle from the current stall rate
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: optional idle gap, then hold the word until ready is seen.
    // Valid stays high across back-to-back words, so at most one update
    // per edge.
    // ------------------------------------------------------------------
    task automatic send_word(logic req, logic signed [DATA_WIDTH-1:0] word_in);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        push_value <= word_in;
        do @(posedge i_clk); while (!in_ready);
        words_sent++;
    endtask

    // a small band around zero, so ties and minimum changes are frequent, and
    // full-range words in equal shares; the rest the extremes, 0, -1 and 1
    function automatic logic signed [DATA_WIDTH-1:0] random_word();
        case ($urandom_range(0, 19))
            15:      return WORD_MIN;
            16:      return WORD_MAX;
            17:      return '0;
            18:      return -1;
            19:      return 1;
            default: begin
                if ($urandom_range(0, 1) == 0)
                    return $signed(DATA_WIDTH'($urandom_range(0, 8))) - 4;
                return DATA_WIDTH'($urandom);
            end
        endcase
    endfunction

    // bursts that lean to push or pop drive the stack to full and to empty
    // repeatedly; pop words carry random payload too, which must be ignored
    task automatic random_phase(int n_words);
        int   burst_left;
        int   push_pct;
        logic req;
        burst_left = 0;
        push_pct   = 50;
        for (int i = 0; i < n_words; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            req = ($urandom_range(0, 99) < push_pct) ? mts_pkg::REQ_PUSH
                                                     : mts_pkg::REQ_POP;
            send_word(req, random_word());
            burst_left--;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // -------------------- directed --------------------
        // pop on an empty stack
        send_word(mts_pkg::REQ_POP, WORD_MAX);
        // fill to the top, with ties on the minimum and both extremes
        foreach (FILL_WORDS[i])
            send_word(mts_pkg::REQ_PUSH, FILL_WORDS[i]);
        // push on a full stack: equal to the minimum, must leave it alone
        send_word(mts_pkg::REQ_PUSH, WORD_MIN);
        // unwind past the duplicated minimum
        repeat (6) send_word(mts_pkg::REQ_POP, '0);
        directed_sent = words_sent;

        // -------------------- random ----------------------
        in_gap_pct    = 6;
        out_stall_pct = 80;
        random_phase(420);

        in_gap_pct    = 80;
        out_stall_pct = 6;
        random_phase(420);

        in_gap_pct    = 0;
        out_stall_pct = 0;
        random_phase(410);

        in_valid <= 1'b0;

        // -------------------- wind-down -------------------
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d request words (%0d directed) under three pressure phases;",
                 words_sent, directed_sent);
        $display("checked %0d result words, %0d full-stack drops, %0d empty pops",
                 checked, full_drops, empty_pops);
        if (pending != 0)
            $display("%0d result words never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: min_tracking_stack_top.f
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/mts_chain.sv
rtl/min_tracking_stack_top.sv
tb/min_tracking_stack_checker.sv
tb/min_tracking_stack_top_tb.sv
